### hw/rtl/bms_pkg.sv
// Shared types and constants for the batch median selector.
package bms_pkg;

    // Width of the reported sample count.
    localparam int unsigned COUNT_WIDTH = 7;

    // Sequencer states, one-hot.
    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_CRD  = 8'b0000_0010,
        S_CLAT = 8'b0000_0100,
        S_SCAN = 8'b0000_1000,
        S_TAIL = 8'b0001_0000,
        S_EVAL = 8'b0010_0000,
        S_AVG  = 8'b0100_0000,
        S_OUT  = 8'b1000_0000
    } bms_state_t;

endpackage

### hw/rtl/bms_sample_store.sv
// Sample store: one write port and one read port with registered read data.
module bms_sample_store #(
    parameter int unsigned DATA_W = 32,
    parameter int unsigned DEPTH  = 64,
    parameter int unsigned ADDR_W = 6
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);
    import bms_pkg::*;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### hw/rtl/batch_median_selector.sv
// Top level of the batch median selector: sample intake, rank sequencer and result register.
//
// Samples are taken one per cycle into an on-chip store until the sample marked last;
// samples beyond CAPACITY are dropped and reported through overflow. The median is then
// found by rank selection with one shared pair of comparators (less than and less or
// equal): each stored sample in turn is read as a candidate and compared with every
// stored sample over one read port of the store, each candidate passing through the states
// CRD, CLAT, SCAN, TAIL and EVAL, and the result is offered after AVG. The sample input
// is not ready from the last sample of a batch until its result transfer. An even count
// gives the floor of the mean of the two middle values. The store needs no clearing after reset.
module batch_median_selector #(
    parameter int unsigned CAPACITY     = 64,
    parameter int unsigned SAMPLE_WIDTH = 32
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  sample_valid,
    output logic                                  sample_ready,
    input  logic signed [SAMPLE_WIDTH-1:0]        sample,
    input  logic                                  last,
    output logic                                  result_valid,
    input  logic                                  result_ready,
    output logic signed [SAMPLE_WIDTH-1:0]        median,
    output logic [bms_pkg::COUNT_WIDTH-1:0]       count,
    output logic                                  overflow
);
    import bms_pkg::*;

    localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned CW = $clog2(CAPACITY + 1);

    bms_state_t state_reg, state_next;

    logic [CW-1:0]                 n_reg, n_next;
    logic                          dropped_reg, dropped_next;
    logic [AW-1:0]                 i_reg, i_next;
    logic [AW-1:0]                 j_reg, j_next;
    logic [CW-1:0]                 lt_reg, lt_next;
    logic [CW-1:0]                 le_reg, le_next;
    logic                          pend_reg, pend_next;
    logic                          fa_reg, fa_next;
    logic                          fb_reg, fb_next;
    logic signed [SAMPLE_WIDTH-1:0] cand_reg, cand_next;
    logic signed [SAMPLE_WIDTH-1:0] a_reg, a_next;
    logic signed [SAMPLE_WIDTH-1:0] b_reg, b_next;
    logic signed [SAMPLE_WIDTH-1:0] median_reg, median_next;

    logic                          take;
    logic                          has_room;
    logic                          wr_en;
    logic [AW-1:0]                 rd_addr;
    logic signed [SAMPLE_WIDTH-1:0] rd_data;
    logic [CW-1:0]                 k_hi;
    logic [CW-1:0]                 k_lo;
    logic                          hit_hi;
    logic                          hit_lo;
    logic                          cmp_lt;
    logic                          cmp_le;
    logic signed [SAMPLE_WIDTH:0]  pair_sum;

    assign take     = sample_valid && sample_ready;
    assign has_room = (n_reg < CW'(CAPACITY));
    assign wr_en    = take && has_room;
    assign rd_addr  = (state_reg == S_CRD) ? i_reg : j_reg;

    bms_sample_store #(
        .DATA_W (SAMPLE_WIDTH),
        .DEPTH  (CAPACITY),
        .ADDR_W (AW)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (n_reg[AW-1:0]),
        .wr_data (sample),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Shared comparators and rank tests.
    assign cmp_lt = (rd_data < cand_reg);
    assign cmp_le = (rd_data <= cand_reg);
    assign k_hi   = n_reg >> 1;
    assign k_lo   = n_reg[0] ? k_hi : (k_hi - CW'(1));
    assign hit_hi = (lt_reg <= k_hi) && (k_hi < le_reg);
    assign hit_lo = (lt_reg <= k_lo) && (k_lo < le_reg);

    // Mean of the two middle values, rounded towards minus infinity.
    assign pair_sum = {a_reg[SAMPLE_WIDTH-1], a_reg} + {b_reg[SAMPLE_WIDTH-1], b_reg};

    // Sequencer.
    always_comb
    begin
        state_next   = state_reg;
        n_next       = n_reg;
        dropped_next = dropped_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        lt_next      = lt_reg;
        le_next      = le_reg;
        pend_next    = pend_reg;
        fa_next      = fa_reg;
        fb_next      = fb_reg;
        cand_next    = cand_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        median_next  = median_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    if (has_room)
                    begin
                        n_next = n_reg + CW'(1);
                    end
                    else
                    begin
                        dropped_next = 1'b1;
                    end
                    if (last)
                    begin
                        i_next     = '0;
                        fa_next    = 1'b0;
                        fb_next    = 1'b0;
                        state_next = S_CRD;
                    end
                end
            end
            S_CRD:
            begin
                state_next = S_CLAT;
            end
            S_CLAT:
            begin
                cand_next  = rd_data;
                j_next     = '0;
                lt_next    = '0;
                le_next    = '0;
                pend_next  = 1'b0;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                pend_next = 1'b1;
                if (pend_reg)
                begin
                    lt_next = lt_reg + CW'(cmp_lt);
                    le_next = le_reg + CW'(cmp_le);
                end
                if (CW'(j_reg) == (n_reg - CW'(1)))
                begin
                    state_next = S_TAIL;
                end
                else
                begin
                    j_next = j_reg + AW'(1);
                end
            end
            S_TAIL:
            begin
                lt_next    = lt_reg + CW'(cmp_lt);
                le_next    = le_reg + CW'(cmp_le);
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                if (hit_lo)
                begin
                    a_next  = cand_reg;
                    fa_next = 1'b1;
                end
                if (hit_hi)
                begin
                    b_next  = cand_reg;
                    fb_next = 1'b1;
                end
                if ((fa_reg || hit_lo) && (fb_reg || hit_hi))
                begin
                    state_next = S_AVG;
                end
                else
                begin
                    i_next     = i_reg + AW'(1);
                    state_next = S_CRD;
                end
            end
            S_AVG:
            begin
                median_next = pair_sum[SAMPLE_WIDTH:1];
                state_next  = S_OUT;
            end
            S_OUT:
            begin
                if (result_ready)
                begin
                    n_next       = '0;
                    dropped_next = 1'b0;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            n_reg       <= '0;
            dropped_reg <= 1'b0;
            i_reg       <= '0;
            j_reg       <= '0;
            lt_reg      <= '0;
            le_reg      <= '0;
            pend_reg    <= 1'b0;
            fa_reg      <= 1'b0;
            fb_reg      <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            n_reg       <= n_next;
            dropped_reg <= dropped_next;
            i_reg       <= i_next;
            j_reg       <= j_next;
            lt_reg      <= lt_next;
            le_reg      <= le_next;
            pend_reg    <= pend_next;
            fa_reg      <= fa_next;
            fb_reg      <= fb_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        cand_reg   <= cand_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        median_reg <= median_next;
    end

    assign sample_ready = (state_reg == S_IDLE);
    assign result_valid = (state_reg == S_OUT);
    assign median       = median_reg;
    assign count        = COUNT_WIDTH'(n_reg);
    assign overflow     = dropped_reg;

    // A result always covers at least one and at most CAPACITY samples.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (n_reg != '0) && (n_reg <= CW'(CAPACITY)))
        else $error("result count out of range");

    // The rank counts of a finished scan are ordered and stay within the batch.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EVAL) |-> (lt_reg <= le_reg) && (le_reg <= n_reg))
        else $error("rank counts inconsistent");

    // A result transfer empties the batch and reopens the sample input.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_ready) |=> sample_ready && (n_reg == '0) && !dropped_reg)
        else $error("batch not cleared after result transfer");

    // Selection never runs past the stored samples.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CRD) |-> (CW'(i_reg) < n_reg))
        else $error("candidate index beyond batch");

endmodule

### dv/tb.sv
// Self-checking testbench for the batch median selector.
`timescale 1ns / 1ps

module tb;

    import bms_pkg::*;

    localparam int SW             = 32;
    localparam int CAP            = 64;
    localparam int COUNT_W        = COUNT_WIDTH;
    localparam int LAT_MAX        = CAP * (CAP + 4) + 2;
    localparam int WATCHDOG_LIMIT = 50000;
    localparam int PHASE_ITEMS    = 340;

    localparam logic signed [SW-1:0] S_MIN = {1'b1, {(SW-1){1'b0}}};
    localparam logic signed [SW-1:0] S_MAX = {1'b0, {(SW-1){1'b1}}};

    // How the values of one random batch are drawn.
    typedef enum int {
        MIX_WIDE,
        MIX_TIES,
        MIX_EXTREME,
        MIX_BLEND
    } value_mix_t;

    typedef struct {
        logic signed [SW-1:0] median;
        logic [COUNT_W-1:0]   count;
        logic                 overflow;
    } median_result_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 sample_valid = 1'b0;
    logic                 sample_ready;
    logic signed [SW-1:0] sample = '0;
    logic                 last = 1'b0;
    logic                 result_valid;
    logic                 result_ready = 1'b0;
    logic signed [SW-1:0] median;
    logic [COUNT_W-1:0]   count;
    logic                 overflow;

    // Predictor state: the samples held in the current batch.
    logic signed [SW-1:0] batch_buf [CAP];
    int unsigned          held = 0;
    logic                 batch_overflowed = 1'b0;
    median_result_t       pending_medians [$];

    int mismatches     = 0;
    int results_seen   = 0;
    int idle_cycles    = 0;
    int send_idle_pct  = 0;
    int ready_stall_pct = 0;

    batch_median_selector #(
        .CAPACITY     (CAP),
        .SAMPLE_WIDTH (SW)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .last         (last),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .median       (median),
        .count        (count),
        .overflow     (overflow)
    );

    always #1 clk = ~clk;

    // Median of the held samples: insertion sort, then the middle value or
    // the floor of the mean of the two middle values over a 33-bit sum.
    function automatic logic signed [SW-1:0] median_of_held();
        logic signed [SW-1:0] ordered [CAP];
        logic signed [SW-1:0] key;
        logic signed [SW:0]   pair_sum;
        int                   i;
        int                   j;
        for (i = 0; i < int'(held); i++)
        begin
            key = batch_buf[i];
            j = i;
            while (j > 0 && ordered[j-1] > key)
            begin
                ordered[j] = ordered[j-1];
                j--;
            end
            ordered[j] = key;
        end
        if (held % 2 == 1)
            return ordered[held / 2];
        pair_sum = $signed({ordered[held/2-1][SW-1], ordered[held/2-1]})
                 + $signed({ordered[held/2][SW-1], ordered[held/2]});
        return pair_sum[SW:1];
    endfunction

    // Update the predicted store with one accepted sample; a last sample
    // closes the batch and queues its expected median.
    function automatic void take_sample(input logic signed [SW-1:0] value,
                                        input logic is_last);
        median_result_t res;
        if (held < CAP)
        begin
            batch_buf[held] = value;
            held++;
        end
        else
            batch_overflowed = 1'b1;
        if (is_last)
        begin
            res.median   = median_of_held();
            res.count    = COUNT_W'(held);
            res.overflow = batch_overflowed;
            pending_medians.insert(pending_medians.size(), res);
            held = 0;
            batch_overflowed = 1'b0;
        end
    endfunction

    function automatic void note_mismatch(input string what);
        mismatches++;
        if (mismatches <= 10)
            $display("ERROR at %0t: %s", $realtime, what);
    endfunction

    function automatic logic signed [SW-1:0] pick_sample(input value_mix_t mix);
        value_mix_t m;
        m = mix;
        if (m == MIX_BLEND)
            m = value_mix_t'($urandom_range(0, 2));
        case (m)
            MIX_TIES:
                return SW'(int'($urandom_range(0, 15)) - 8);
            MIX_EXTREME:
                case ($urandom_range(0, 3))
                    0: return S_MIN;
                    1: return S_MAX;
                    2: return S_MIN + 1;
                    default: return S_MAX - 1;
                endcase
            default:
                return $urandom;
        endcase
    endfunction

    // One sample transfer, with random idle cycles ahead of it.
    task automatic send_sample(input logic signed [SW-1:0] value, input logic is_last);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            sample_valid <= 1'b0;
            @(negedge clk);
        end
        sample_valid <= 1'b1;
        sample       <= value;
        last         <= is_last;
        @(posedge clk);
        while (!sample_ready)
            @(posedge clk);
        take_sample(value, is_last);
    endtask

    task automatic test_single_sample();
        send_sample(S_MIN, 1'b1);
        send_sample(S_MAX, 1'b1);
        send_sample('0, 1'b1);
        send_sample(-1, 1'b1);
    endtask

    // Even counts: the two middle values are averaged with floor, and the
    // sum must not wrap at the extremes.
    task automatic test_even_average();
        send_sample(S_MAX, 1'b0);
        send_sample(S_MAX - 1, 1'b1);
        send_sample(S_MIN, 1'b0);
        send_sample(S_MIN + 1, 1'b1);
        send_sample(S_MAX, 1'b0);
        send_sample(S_MIN, 1'b1);
        send_sample(3, 1'b0);
        send_sample(-4, 1'b1);
    endtask

    // Odd counts with duplicates and samples in falling order.
    task automatic test_odd_middle();
        send_sample(9, 1'b0);
        send_sample(-2, 1'b0);
        send_sample(9, 1'b0);
        send_sample(S_MIN, 1'b0);
        send_sample(5, 1'b1);
        send_sample(S_MAX, 1'b0);
        send_sample(0, 1'b0);
        send_sample(S_MIN, 1'b1);
    endtask

    // A batch that fills the store exactly, then one whose tail and last
    // sample are dropped.
    task automatic test_store_full();
        int i;
        for (i = 0; i < CAP; i++)
            send_sample($urandom, i == CAP - 1);
        for (i = 0; i < CAP + 2; i++)
            send_sample(pick_sample(MIX_BLEND), i == CAP + 1);
    endtask

    // The sender holds off until the previous median has been taken.
    task automatic test_drain_pause();
        send_sample(pick_sample(MIX_WIDE), 1'b0);
        send_sample(pick_sample(MIX_WIDE), 1'b1);
        @(negedge clk);
        sample_valid <= 1'b0;
        while (pending_medians.size() != 0)
            @(posedge clk);
        send_sample(pick_sample(MIX_TIES), 1'b0);
        send_sample(pick_sample(MIX_TIES), 1'b0);
        send_sample(pick_sample(MIX_TIES), 1'b1);
    endtask

    // Random batches, mostly short, with the odd one near, at or past capacity.
    task automatic test_random_batches(input int n_items, input int idle_pct,
                                       input int stall_pct);
        int         sent;
        int         len;
        int         sel;
        int         i;
        value_mix_t mix;
        sent = 0;
        send_idle_pct = idle_pct;
        ready_stall_pct = stall_pct;
        while (sent < n_items)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 70)
                len = $urandom_range(1, 8);
            else if (sel < 96)
                len = $urandom_range(9, 24);
            else
                len = $urandom_range(CAP - 4, CAP + 6);
            mix = value_mix_t'($urandom_range(0, 3));
            for (i = 0; i < len; i++)
                send_sample(pick_sample(mix), i == len - 1);
            sent += len;
        end
    endtask

    // Receiver stalls at random.
    always @(negedge clk)
        result_ready <= ($urandom_range(0, 99) >= ready_stall_pct);

    // Check each result transfer against the oldest expected median.
    always @(posedge clk)
    begin
        median_result_t want;
        if (rst_n && result_valid && result_ready)
        begin
            results_seen++;
            if (pending_medians.size() == 0)
                note_mismatch($sformatf("result %0d with none expected: median %0d count %0d",
                                        results_seen, median, count));
            else
            begin
                want = pending_medians.pop_front();
                if (median !== want.median || count !== want.count
                    || overflow !== want.overflow)
                    note_mismatch($sformatf(
                        "result %0d: expected median %0d count %0d overflow %0b, got %0d %0d %0b",
                        results_seen, want.median, want.count, want.overflow,
                        median, count, overflow));
            end
        end
    end

    // Watchdog on cycles with no transfer on either side.
    always @(posedge clk)
    begin
        if ((sample_valid && sample_ready) || (result_valid && result_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_single_sample();
        test_even_average();
        test_odd_middle();
        test_store_full();
        test_drain_pause();
        test_random_batches(PHASE_ITEMS, 0, 0);
        test_random_batches(PHASE_ITEMS, 57, 0);
        test_random_batches(PHASE_ITEMS, 0, 57);
        test_random_batches(PHASE_ITEMS, 8, 8);

        @(negedge clk);
        sample_valid <= 1'b0;
        while (pending_medians.size() != 0)
            @(posedge clk);
        repeat (LAT_MAX) @(posedge clk);

        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

### files.f
hw/rtl/bms_pkg.sv
hw/rtl/bms_sample_store.sv
hw/rtl/batch_median_selector.sv
dv/tb.sv
